// File: sv/nvme_io_queue_pair_host_macros.svh
// assertion macros shared by the queue pair rtl
`ifndef NVME_IO_QUEUE_PAIR_HOST_MACROS_SVH
`define NVME_IO_QUEUE_PAIR_HOST_MACROS_SVH

// property checked on every rising edge outside reset
`define NVQP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define NVQP_ASSERT_NEXT(label, ante, cons, msg) \
  `NVQP_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: sv/nvqp_pkg.sv
// ----------------------------------------------------------------------------
// nvqp_pkg
// shared types and codes of the nvme i/o queue pair host block
// ----------------------------------------------------------------------------
package nvqp_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // operation codes
  localparam logic [1:0] OP_READ     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FORMED  = 2'd0;
  localparam logic [1:0] KIND_SUCCESS = 2'd1;
  localparam logic [1:0] KIND_PENDING = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // nvm command opcodes
  localparam logic [7:0] OPC_READ  = 8'h02;
  localparam logic [7:0] OPC_WRITE = 8'h01;

  // doorbell region start within the bar
  localparam logic [34:0] DOORBELL_BASE = 35'h1000;

  // configuration register indexes
  localparam logic [1:0] CFG_DSTRD = 2'd0;
  localparam logic [1:0] CFG_NSID  = 2'd1;
  localparam logic [1:0] CFG_QID   = 2'd2;

  localparam int CFG_DATA_W = 32;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_known;
  } dp_status_t;

endpackage

// File: sv/nvqp_datapath.sv
// ----------------------------------------------------------------------------
// nvqp_datapath
// input capture, queue pointers, command forming and doorbell arithmetic
// ----------------------------------------------------------------------------
`include "nvme_io_queue_pair_host_macros.svh"

module nvqp_datapath
  import nvqp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            operation,
  input  logic [63:0]           start_block,
  input  logic [16:0]           block_count,
  input  logic [63:0]           buffer_address,
  input  logic [15:0]           completion_status_word,
  output logic [1:0]            result_kind,
  output logic [1:0]            slot_index,
  output logic [7:0]            command_opcode,
  output logic [15:0]           command_identifier,
  output logic [31:0]           command_namespace,
  output logic [63:0]           data_pointer,
  output logic [31:0]           lba_low_word,
  output logic [31:0]           lba_high_word,
  output logic [15:0]           blocks_minus_one,
  output logic [34:0]           doorbell_offset,
  output logic [1:0]            doorbell_value,
  output logic [14:0]           error_code
);

  localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  // configuration registers
  logic [3:0]  dstrd;
  logic [31:0] nsid;
  logic [15:0] qid;

  // captured item
  logic [1:0]  op_q;
  logic [63:0] lba_q;
  logic [16:0] count_q;
  logic [63:0] buf_q;
  logic [15:0] word_q;

  // queue state
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head;
  logic             phase;

  logic [PTR_W-1:0] tail_next;
  logic [PTR_W-1:0] head_next;
  logic             is_submit;
  logic             is_complete;
  logic             is_pending;
  logic [15:0]      nlb;
  logic [16:0]      db_index;
  logic [34:0]      db_offset;
  logic [15:0]      tail_ext;
  logic [15:0]      head_ext;
  logic [15:0]      tail_next_ext;
  logic [15:0]      head_next_ext;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dstrd <= 4'd0;
      nsid  <= 32'd1;
      qid   <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DSTRD: dstrd <= cfg_data[3:0];
        CFG_NSID:  nsid  <= cfg_data[31:0];
        CFG_QID:   qid   <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= operation;
      lba_q   <= start_block;
      count_q <= block_count;
      buf_q   <= buffer_address;
      word_q  <= completion_status_word;
    end
  end

  // decode
  assign is_submit   = (op_q == OP_READ) || (op_q == OP_WRITE);
  assign is_complete = (op_q == OP_COMPLETE);
  assign is_pending  = word_q[0] != phase;
  assign status.op_known = is_submit || is_complete;

  // pointer advance with wrap
  assign tail_next = (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);
  assign head_next = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);

  assign tail_ext      = 16'(tail);
  assign head_ext      = 16'(head);
  assign tail_next_ext = 16'(tail_next);
  assign head_next_ext = 16'(head_next);

  // zero-based block count, saturating at both ends
  always_comb begin
    if (count_q == 17'd0) begin
      nlb = 16'd0;
    end else if (count_q[16] && (count_q[15:0] != 16'd0)) begin
      nlb = 16'hFFFF;
    end else begin
      nlb = 16'(count_q - 17'd1);
    end
  end

  // doorbell: base + (2*qid + which) * (4 << dstrd)
  assign db_index  = {qid, is_complete};
  assign db_offset = DOORBELL_BASE + ((35'(db_index) << dstrd) << 2);

  // queue state update
  always_ff @(posedge clk) begin
    if (rst) begin
      tail  <= '0;
      head  <= '0;
      phase <= 1'b1;
    end else if (cmd.execute) begin
      if (is_submit) begin
        tail <= tail_next;
      end else if (is_complete && !is_pending) begin
        head <= head_next;
        if (head == LAST_SLOT) begin
          phase <= ~phase;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      result_kind        <= KIND_FORMED;
      slot_index         <= tail_ext[1:0];
      command_opcode     <= 8'd0;
      command_identifier <= 16'd0;
      command_namespace  <= 32'd0;
      data_pointer       <= 64'd0;
      lba_low_word       <= 32'd0;
      lba_high_word      <= 32'd0;
      blocks_minus_one   <= 16'd0;
      doorbell_offset    <= 35'd0;
      doorbell_value     <= 2'd0;
      error_code         <= 15'd0;
      if (is_submit) begin
        command_opcode     <= (op_q == OP_READ) ? OPC_READ : OPC_WRITE;
        command_identifier <= tail_ext;
        command_namespace  <= nsid;
        data_pointer       <= buf_q;
        lba_low_word       <= lba_q[31:0];
        lba_high_word      <= lba_q[63:32];
        blocks_minus_one   <= nlb;
        doorbell_offset    <= db_offset;
        doorbell_value     <= tail_next_ext[1:0];
      end else begin
        slot_index <= head_ext[1:0];
        if (is_pending) begin
          result_kind <= KIND_PENDING;
        end else begin
          result_kind     <= (word_q[15:1] != 15'd0) ? KIND_ERROR : KIND_SUCCESS;
          doorbell_offset <= db_offset;
          doorbell_value  <= head_next_ext[1:0];
          error_code      <= word_q[15:1];
        end
      end
    end
  end

  // a pending completion leaves the head and phase alone
  `NVQP_ASSERT_NEXT(a_pending_holds_head, cmd.execute && is_complete && is_pending,
    $stable(head) && $stable(phase), "pending completion moved the head")
  // every submit moves the tail
  `NVQP_ASSERT_NEXT(a_submit_moves_tail, cmd.execute && is_submit,
    tail != $past(tail), "submit did not advance the tail")

endmodule

// File: sv/nvqp_ctrl.sv
// ----------------------------------------------------------------------------
// nvqp_ctrl
// sequencer: accepts a command, runs the execute state and, for a known operation, raises done
// ----------------------------------------------------------------------------
`include "nvme_io_queue_pair_host_macros.svh"

module nvqp_ctrl
  import nvqp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // next state
  always_comb begin
    case (state)
      ST_IDLE: state_next = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC) && status.op_known;
    end
  end

  // datapath commands
  assign busy        = (state != ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && start;
  assign cmd.execute = (state == ST_EXEC);

  // a result only follows an execute cycle
  `NVQP_ASSERT(a_done_after_exec, done |-> $past(state == ST_EXEC),
    "done without a preceding execute cycle")
  // an accepted transfer always moves into execute
  `NVQP_ASSERT_NEXT(a_start_enters_exec, start && !busy, state == ST_EXEC,
    "accepted command did not execute")

endmodule

// File: sv/nvme_io_queue_pair_host.sv
// ----------------------------------------------------------------------------
// nvme_io_queue_pair_host
// host side of one nvme i/o submission/completion queue pair
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. operation selects
//   submit read, submit write or examine the completion entry at the head;
//   code 3 is taken but raises no done and leaves the queue state alone.
//   A submit forms the command fields for the current tail slot and reports
//   the submission doorbell offset and new tail. A completion reports
//   pending on phase mismatch, else success or error with the completion
//   doorbell offset and new head.
//   A command is captured in the idle state and executed in the execute
//   state; done pulses for one cycle the cycle after, with the result
//   on the output ports. The two-state sequencer takes no new command
//   while busy but can take one while done is high. Results must be
//   taken when done is high; there is no backpressure.
//   Configuration (cfg_write, cfg_index, cfg_data) writes take effect at once;
//   the user must issue them while the block is idle; it is not enforced.
//   Reset: tail and head 0, expected phase 1, stride exponent 0, namespace
//   1, queue id 1.
// ----------------------------------------------------------------------------
module nvme_io_queue_pair_host
  import nvqp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [63:0]           start_block,
  input  logic [16:0]           block_count,
  input  logic [63:0]           buffer_address,
  input  logic [15:0]           completion_status_word,
  output logic                  done,
  output logic [1:0]            result_kind,
  output logic [1:0]            slot_index,
  output logic [7:0]            command_opcode,
  output logic [15:0]           command_identifier,
  output logic [31:0]           command_namespace,
  output logic [63:0]           data_pointer,
  output logic [31:0]           lba_low_word,
  output logic [31:0]           lba_high_word,
  output logic [15:0]           blocks_minus_one,
  output logic [34:0]           doorbell_offset,
  output logic [1:0]            doorbell_value,
  output logic [14:0]           error_code
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  nvqp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  // datapath
  nvqp_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .status                 (status),
    .cfg_write              (cfg_write),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .operation              (operation),
    .start_block            (start_block),
    .block_count            (block_count),
    .buffer_address         (buffer_address),
    .completion_status_word (completion_status_word),
    .result_kind            (result_kind),
    .slot_index             (slot_index),
    .command_opcode         (command_opcode),
    .command_identifier     (command_identifier),
    .command_namespace      (command_namespace),
    .data_pointer           (data_pointer),
    .lba_low_word           (lba_low_word),
    .lba_high_word          (lba_high_word),
    .blocks_minus_one       (blocks_minus_one),
    .doorbell_offset        (doorbell_offset),
    .doorbell_value         (doorbell_value),
    .error_code             (error_code)
  );

endmodule
